// ===== rtl/gsg_pkg.sv =====
// Package: shared types, register indexes and codes of the geofence safety gate.
`default_nettype none
package gsg_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int TOTAL_PLANES = 6;
   localparam int POS_W = 17;
   localparam int PROD_W = 2 * POS_W - 1;
   localparam int ACC_W = 35;
   localparam int OFFSET_W = 18;
   localparam int FRAC_BITS = 14;

   localparam logic [CSR_IDX_W-1:0] REG_PLANE_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HULL_MARGIN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNC_LIMIT = 3'd7;

   localparam logic [14:0] MARGIN_RESET = 15'd30;
   localparam logic [15:0] LIMIT_RESET = 16'd20;
   localparam logic [19:0] STALE_LIMIT_US = 20'd20000;

   localparam logic [1:0] ACT_POSE = 2'd0;
   localparam logic [1:0] ACT_COMMAND = 2'd1;
   localparam logic [1:0] ACT_MODE_REQ = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   localparam logic [1:0] KIND_BODY_RATE = 2'd0;
   localparam logic [1:0] KIND_THRUST_TORQUE = 2'd1;
   localparam logic [1:0] KIND_MOTORS = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_BODY_RATE = 2'd1;
   localparam logic [1:0] MODE_THRUST_TORQUE = 2'd2;
   localparam logic [1:0] MODE_ACTUATOR = 2'd3;

   localparam int FLAG_UNCERTAIN_BIT = 0;
   localparam int FLAG_OOB_BIT = 1;

   typedef struct packed {
      logic signed [15:0] d;
      logic signed [15:0] nz;
      logic signed [15:0] ny;
      logic signed [15:0] nx;
   } plane_type;

   typedef struct packed {
      logic [14:0] hull_margin;
      logic [15:0] uncertainty_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [15:0]        horiz_error;
      logic [15:0]        vert_error;
      logic [19:0]        cmd_age_us;
      logic [1:0]         cmd_kind;
      logic               offboard_active;
   } req_type;

   typedef struct packed {
      logic [1:0] flags;
      logic [1:0] land_count;
      logic [1:0] control_mode;
      logic       forward_setpoint;
      logic       request_ok;
      logic       kind_error;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/gsg_csr.sv =====
// Configuration registers: plane coefficients, hull margin and uncertainty limit.
`default_nettype none
module gsg_csr
   import gsg_pkg::*;
#(
   parameter int PLANE_COUNT = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output plane_type                  planes [PLANE_COUNT],
   output cfg_type                    cfg
);

   plane_type planes_ff [PLANE_COUNT];
   cfg_type   cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            planes_ff[i] <= '0;
         end
         cfg_ff.hull_margin <= MARGIN_RESET;
         cfg_ff.uncertainty_limit <= LIMIT_RESET;
      end else if (wr_en) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            if (wr_index == REG_PLANE_A + CSR_IDX_W'(i)) begin
               planes_ff[i] <= plane_type'(wr_data);
            end
         end
         if (wr_index == REG_HULL_MARGIN) begin
            cfg_ff.hull_margin <= wr_data[14:0];
         end
         if (wr_index == REG_UNC_LIMIT) begin
            cfg_ff.uncertainty_limit <= wr_data[15:0];
         end
      end
   end

   assign planes = planes_ff;
   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/gsg_plane_check.sv =====
// One half-space test: n.p + (d - margin) * 2^14 > 0 in exact fixed point.
`default_nettype none
module gsg_plane_check
   import gsg_pkg::*;
(
   input  wire plane_type            plane,
   input  wire logic signed [POS_W-1:0] px,
   input  wire logic signed [POS_W-1:0] py,
   input  wire logic signed [POS_W-1:0] pz,
   input  wire logic [14:0]          margin,
   output logic                      fail
);

   logic signed [POS_W-1:0]    nx_w, ny_w, nz_w;
   logic signed [PROD_W-1:0]   prod_x, prod_y, prod_z;
   logic signed [OFFSET_W-1:0] offset;
   logic signed [ACC_W-1:0]    acc;

   assign nx_w = POS_W'(plane.nx);
   assign ny_w = POS_W'(plane.ny);
   assign nz_w = POS_W'(plane.nz);

   assign prod_x = nx_w * px;
   assign prod_y = ny_w * py;
   assign prod_z = nz_w * pz;

   assign offset = OFFSET_W'(plane.d) - $signed({3'b000, margin});

   assign acc = ACC_W'(prod_x) + ACC_W'(prod_y) + ACC_W'(prod_z)
              + ACC_W'($signed({offset, {FRAC_BITS{1'b0}}}));

   assign fail = (acc > 0);

endmodule
`default_nettype wire

// ===== rtl/gsg_policy.sv =====
// Decision logic: flag update, land requests, command gating and mode request grants for one beat.
`default_nettype none
module gsg_policy
   import gsg_pkg::*;
#(
   parameter int PLANE_COUNT = 6
) (
   input  wire req_type              item,
   input  wire logic [1:0]           flags,
   input  wire logic [PLANE_COUNT-1:0] plane_fail,
   input  wire logic [15:0]          limit,
   output rsp_type                   result,
   output logic [1:0]                flags_next
);

   logic uncertain;
   logic outside;
   logic stale;
   logic unsafe;

   assign uncertain = (item.horiz_error > limit) || (item.vert_error > limit);
   assign outside = |plane_fail;
   assign stale = (item.cmd_age_us > STALE_LIMIT_US);
   assign unsafe = (flags != 2'b00);

   always_comb begin
      result = '0;
      flags_next = flags;
      unique case (item.action)
         ACT_POSE: begin
            flags_next[FLAG_UNCERTAIN_BIT] = uncertain;
            flags_next[FLAG_OOB_BIT] = outside;
            result.land_count = {1'b0, uncertain} + {1'b0, outside};
         end
         ACT_COMMAND: begin
            result.land_count = {1'b0, stale} + {1'b0, unsafe};
            if (!unsafe && !stale) begin
               unique case (item.cmd_kind)
                  KIND_BODY_RATE: result.control_mode = MODE_BODY_RATE;
                  KIND_THRUST_TORQUE: result.control_mode = MODE_THRUST_TORQUE;
                  KIND_MOTORS: result.control_mode = MODE_ACTUATOR;
                  default: result.control_mode = MODE_NONE;
               endcase
               result.kind_error = (item.cmd_kind == KIND_UNKNOWN);
               result.forward_setpoint = (item.cmd_kind != KIND_UNKNOWN)
                                       && item.offboard_active;
            end
         end
         ACT_MODE_REQ: begin
            result.request_ok = !unsafe;
         end
         default: begin
         end
      endcase
      result.flags = flags_next;
   end

endmodule
`default_nettype wire

// ===== rtl/geofence_safety_gate_unit.sv =====
// Geofence safety gate: one item per clock cycle while rsp_stall lets results leave.
// Each beat is captured in an input register; the plane dot products, the
// uncertainty compare and the gating decision then run combinationally into
// the result register and the kept flags, so the next beat sees the flags
// this one leaves. The path is set by the parallel 16x17 plane multiplies
// and their four-term sum. The result register frees as soon as its beat is
// taken, so req_stall only rises while both registers are full and rsp_stall
// is high. Configuration writes complete at once (csr_ready is always high);
// the user must make them only while idle, which the block does not enforce.
`default_nettype none
module geofence_safety_gate_unit
   import gsg_pkg::*;
#(
   parameter int PLANE_COUNT = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   plane_type planes [PLANE_COUNT];
   cfg_type   cfg;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    s2_valid_ff, s2_valid_in;
   rsp_type s2_data_ff;
   logic [1:0] flags_ff;

   logic s2_free;
   logic s1_move;
   logic req_take;

   logic signed [POS_W-1:0] px, py, pz;
   logic [PLANE_COUNT-1:0]  plane_fail;
   rsp_type                 result;
   logic [1:0]              flags_next;

   assign csr_ready = 1'b1;

   gsg_csr #(
      .PLANE_COUNT(PLANE_COUNT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .planes   (planes),
      .cfg      (cfg)
   );

   // FRD to FLU: y and z change sign
   assign px = POS_W'(s1_data_ff.pos_x);
   assign py = -POS_W'(s1_data_ff.pos_y);
   assign pz = -POS_W'(s1_data_ff.pos_z);

   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
      gsg_plane_check u_plane (
         .plane  (planes[i]),
         .px     (px),
         .py     (py),
         .pz     (pz),
         .margin (cfg.hull_margin),
         .fail   (plane_fail[i])
      );
   end

   gsg_policy #(
      .PLANE_COUNT(PLANE_COUNT)
   ) u_policy (
      .item       (s1_data_ff),
      .flags      (flags_ff),
      .plane_fail (plane_fail),
      .limit      (cfg.uncertainty_limit),
      .result     (result),
      .flags_next (flags_next)
   );

   assign s2_free = !s2_valid_ff || !rsp_stall;
   assign s1_move = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_take = req_valid && !req_stall;

   assign s1_valid_in = req_take || (s1_valid_ff && !s2_free);
   assign s2_valid_in = s1_move || (s2_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         flags_ff <= 2'b00;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (s1_move) begin
            flags_ff <= flags_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         s2_data_ff <= result;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data = s2_data_ff;

   // flags only move on a pose beat leaving the input register
   a_flags_pose_only: assert property (@(posedge clock) disable iff (reset)
      !$stable(flags_ff) |-> $past(reset)
         || $past(s1_move && s1_data_ff.action == ACT_POSE))
      else $error("flags changed without a pose beat");

   a_forward_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.forward_setpoint |->
         rsp_data.flags == 2'b00 && rsp_data.control_mode != MODE_NONE)
      else $error("setpoint forwarded while unsafe or without a mode");

   a_request_ok_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.request_ok |-> rsp_data.flags == 2'b00
         && rsp_data.land_count == 2'd0)
      else $error("mode request granted with a flag set");

   a_kind_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind_error |->
         rsp_data.control_mode == MODE_NONE && !rsp_data.forward_setpoint)
      else $error("unknown kind published a mode");

endmodule
`default_nettype wire

// ===== sim/geofence_safety_gate_unit_tb.sv =====
// Testbench for the geofence safety gate: random and directed beats checked against a predictor.
`default_nettype none
module geofence_safety_gate_unit_tb;
   import gsg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GATE_PLANES = 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 130;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // gate state and configuration as the block should hold them
   plane_type   plane_cfg [TOTAL_PLANES] = '{default: '0};
   logic [14:0] margin_cfg = MARGIN_RESET;
   logic [15:0] limit_cfg = LIMIT_RESET;
   logic [1:0]  gate_flags = '0;
   plane_type   next_planes [TOTAL_PLANES];

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      gap_pct = 33;
   int      mismatch_count = 0;
   int      cycle_count = 0;

   geofence_safety_gate_unit #(.PLANE_COUNT(GATE_PLANES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic point_outside(req_type r);
      longint px, py, pz, acc;
      logic   outside;
      px = r.pos_x;
      py = -longint'(r.pos_y);
      pz = -longint'(r.pos_z);
      outside = 1'b0;
      for (int i = 0; i < GATE_PLANES; i++) begin
         acc = plane_cfg[i].nx * px + plane_cfg[i].ny * py + plane_cfg[i].nz * pz;
         acc += (longint'(plane_cfg[i].d) - longint'(margin_cfg)) * 16384;
         if (acc > 0) outside = 1'b1;
      end
      return outside;
   endfunction

   function automatic rsp_type gate_outcome(req_type r);
      rsp_type o;
      logic    stale;
      o = '0;
      case (r.action)
         ACT_POSE: begin
            if (r.horiz_error > limit_cfg || r.vert_error > limit_cfg) begin
               gate_flags[FLAG_UNCERTAIN_BIT] = 1'b1;
               o.land_count = o.land_count + 2'd1;
            end else begin
               gate_flags[FLAG_UNCERTAIN_BIT] = 1'b0;
            end
            if (point_outside(r)) begin
               gate_flags[FLAG_OOB_BIT] = 1'b1;
               o.land_count = o.land_count + 2'd1;
            end else begin
               gate_flags[FLAG_OOB_BIT] = 1'b0;
            end
         end
         ACT_COMMAND: begin
            stale = r.cmd_age_us > STALE_LIMIT_US;
            if (stale) o.land_count = o.land_count + 2'd1;
            if (gate_flags != 2'b00) begin
               o.land_count = o.land_count + 2'd1;
            end else if (!stale) begin
               case (r.cmd_kind)
                  KIND_BODY_RATE:     o.control_mode = MODE_BODY_RATE;
                  KIND_THRUST_TORQUE: o.control_mode = MODE_THRUST_TORQUE;
                  KIND_MOTORS:        o.control_mode = MODE_ACTUATOR;
                  default:            o.kind_error = 1'b1;
               endcase
               if (r.cmd_kind != KIND_UNKNOWN) o.forward_setpoint = r.offboard_active;
            end
         end
         ACT_MODE_REQ: o.request_ok = (gate_flags == 2'b00);
         default: ;
      endcase
      o.flags = gate_flags;
      return o;
   endfunction

   function automatic req_type random_item(int span);
      req_type r;
      r = '0;
      r.action = ($urandom_range(99) < 4) ? ACT_NONE : 2'($urandom_range(2));
      if ($urandom_range(3) == 0) begin
         r.pos_x = 16'($urandom);
         r.pos_y = 16'($urandom);
         r.pos_z = 16'($urandom);
      end else begin
         r.pos_x = 16'($urandom_range(2 * span) - span);
         r.pos_y = 16'($urandom_range(2 * span) - span);
         r.pos_z = 16'($urandom_range(2 * span) - span);
      end
      if ($urandom_range(1) == 0) begin
         r.horiz_error = 16'(limit_cfg + $urandom_range(6) - 3);
         r.vert_error = 16'(limit_cfg + $urandom_range(6) - 3);
      end else begin
         r.horiz_error = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(40));
         r.vert_error = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(40));
      end
      case ($urandom_range(3))
         0, 1: r.cmd_age_us = 20'(STALE_LIMIT_US + $urandom_range(10) - 5);
         2:    r.cmd_age_us = 20'($urandom);
         default: r.cmd_age_us = 20'($urandom_range(19999));
      endcase
      r.cmd_kind = 2'($urandom);
      r.offboard_active = 1'($urandom);
      return r;
   endfunction

   task automatic add_item(req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_HULL_MARGIN) margin_cfg = value[14:0];
      else if (idx == REG_UNC_LIMIT) limit_cfg = value[15:0];
      else plane_cfg[idx] = value;
   endtask

   task automatic configure(logic [14:0] margin, logic [15:0] limit);
      for (int i = 0; i < TOTAL_PLANES; i++)
         write_csr(REG_PLANE_A + CSR_IDX_W'(i), next_planes[i]);
      write_csr(REG_HULL_MARGIN, CSR_DATA_W'(margin));
      write_csr(REG_UNC_LIMIT, CSR_DATA_W'(limit));
      csr_valid <= 1'b0;
   endtask

   task automatic box_planes(int half);
      for (int i = 0; i < TOTAL_PLANES; i++) begin
         next_planes[i] = '0;
         next_planes[i].d = 16'(-half);
         case (i / 2)
            0: next_planes[i].nx = (i % 2) ? -16'sd16384 : 16'sd16384;
            1: next_planes[i].ny = (i % 2) ? -16'sd16384 : 16'sd16384;
            default: next_planes[i].nz = (i % 2) ? -16'sd16384 : 16'sd16384;
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_random(int span);
      @(negedge clock);
      repeat (RANDOM_ITEMS) add_item(random_item(span));
      wait_drained();
   endtask

   task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.insert(expected_rsps.size(), gate_outcome(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_stall <= ($urandom_range(99) < gap_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("flags", want.flags, rsp_data.flags);
            check_field("land_count", want.land_count, rsp_data.land_count);
            check_field("control_mode", want.control_mode, rsp_data.control_mode);
            check_field("forward_setpoint", 2'(want.forward_setpoint),
                        2'(rsp_data.forward_setpoint));
            check_field("request_ok", 2'(want.request_ok), 2'(rsp_data.request_ok));
            check_field("kind_error", 2'(want.kind_error), 2'(rsp_data.kind_error));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_type it;
      int      half;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // reset configuration: open fence, margin 30, limit 20
      @(negedge clock);
      it = '0;
      it.action = ACT_MODE_REQ;
      add_item(it);
      it.action = ACT_COMMAND;
      it.offboard_active = 1'b1;
      for (int k = 0; k < 4; k++) begin
         it.cmd_kind = 2'(k);
         add_item(it);
      end
      it.cmd_kind = KIND_MOTORS;
      it.offboard_active = 1'b0;
      add_item(it);
      it.offboard_active = 1'b1;
      it.cmd_age_us = STALE_LIMIT_US;
      add_item(it);
      it.cmd_age_us = STALE_LIMIT_US + 20'd1;
      add_item(it);
      it.cmd_age_us = 20'hFFFFF;
      add_item(it);
      it = '0;
      it.horiz_error = LIMIT_RESET + 16'd1;
      add_item(it);
      it.action = ACT_COMMAND;
      add_item(it);
      it.cmd_age_us = 20'hFFFFF;
      add_item(it);
      it.action = ACT_MODE_REQ;
      add_item(it);
      it = '0;
      it.vert_error = 16'hFFFF;
      add_item(it);
      it.horiz_error = LIMIT_RESET;
      it.vert_error = LIMIT_RESET;
      add_item(it);
      it = '0;
      it.action = ACT_NONE;
      add_item(it);
      wait_drained();

      // box of half width 1000
      box_planes(1000);
      configure(15'd30, 16'd20);
      @(negedge clock);
      it = '0;
      add_item(it);
      it.pos_x = 16'sd1030;
      add_item(it);
      it.pos_x = 16'sd1031;
      add_item(it);
      it.pos_x = '0;
      it.pos_y = -16'sd32768;
      add_item(it);
      it.pos_y = '0;
      it.pos_z = 16'sd32767;
      it.horiz_error = 16'hFFFF;
      add_item(it);
      it.action = ACT_COMMAND;
      it.cmd_age_us = 20'hFFFFF;
      add_item(it);
      it = '0;
      add_item(it);
      it = '1;
      it.action = ACT_POSE;
      add_item(it);
      wait_drained();
      queue_random(1300);

      // random box, no margin, zero limit, no idling
      half = $urandom_range(200, 5000);
      box_planes(half);
      configure(15'd0, 16'd0);
      gap_pct = 0;
      queue_random(half + half / 3);
      gap_pct = 33;

      // arbitrary planes, widest margin and limit
      for (int i = 0; i < TOTAL_PLANES; i++) next_planes[i] = {$urandom, $urandom};
      configure(15'h7FFF, 16'hFFFF);
      queue_random(32767);

      // extreme coefficients
      for (int i = 0; i < TOTAL_PLANES; i++)
         next_planes[i] = (i % 2) ? 64'h7FFF_7FFF_7FFF_7FFF : 64'h8000_8000_8000_8000;
      configure(15'($urandom), 16'($urandom));
      queue_random(32767);

      // tilted planes of moderate size
      for (int i = 0; i < TOTAL_PLANES; i++) begin
         next_planes[i].nx = 16'($urandom_range(32768) - 16384);
         next_planes[i].ny = 16'($urandom_range(32768) - 16384);
         next_planes[i].nz = 16'($urandom_range(32768) - 16384);
         next_planes[i].d = 16'($urandom_range(6000) - 3000);
      end
      configure(15'($urandom_range(200)), 16'($urandom_range(100)));
      queue_random(3000);

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/gsg_pkg.sv
rtl/gsg_csr.sv
rtl/gsg_plane_check.sv
rtl/gsg_policy.sv
rtl/geofence_safety_gate_unit.sv
sim/geofence_safety_gate_unit_tb.sv
